// File: design/pgw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package pgw_pkg;

  localparam int ROOT_W   = 6;
  localparam int VA_W     = 48;
  localparam int WIDX_W   = 15;
  localparam int WORD_W   = 64;
  localparam int PA_W     = 52;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 2;
  localparam int IDX_W    = 9;
  localparam int LEVEL_W  = 2;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_WRITE     = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_STORE = 2'd2;

  localparam logic [SIZE_W-1:0] SZ_4K = 2'd0;
  localparam logic [SIZE_W-1:0] SZ_2M = 2'd1;
  localparam logic [SIZE_W-1:0] SZ_1G = 2'd2;

  localparam logic [LEVEL_W-1:0] LVL_PML4 = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_PD   = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_PT   = 2'd3;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_HUGE    = 7;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK
  } state_t;

endpackage

// File: design/pgw_channels.sv
// ----------------------------------------------------------------------------
// Page table walker channels
// Valid/ready interfaces for the request and result channels.
// ----------------------------------------------------------------------------
interface pgw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [pgw_pkg::VA_W-1:0]      virt_addr;
  logic [pgw_pkg::WIDX_W-1:0]    word_index;
  logic [pgw_pkg::WORD_W-1:0]    word_value;

  modport source (output valid, opcode, virt_addr, word_index, word_value, input ready);
  modport sink   (input valid, opcode, virt_addr, word_index, word_value, output ready);
endinterface

interface pgw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pgw_pkg::STATUS_W-1:0]  status;
  logic [pgw_pkg::PA_W-1:0]      phys_addr;
  logic [pgw_pkg::SIZE_W-1:0]    pg_size;
  logic [pgw_pkg::WORD_W-1:0]    leaf_word;

  modport source (output valid, status, phys_addr, pg_size, leaf_word, input ready);
  modport sink   (input valid, status, phys_addr, pg_size, leaf_word, output ready);
endinterface

// File: design/pgw_ram.sv
// ----------------------------------------------------------------------------
// Page table walker RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module pgw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// Four-level page table walker
// Translates 48-bit virtual addresses by walking tables held in one RAM.
// ----------------------------------------------------------------------------
// A translate request reads one table word per level, up to four levels, through the
// single RAM read port; its result is loaded when the walk ends and the output
// register is free. A write request or a root outside the store gives its result
// without a walk. A waiting result holds off the next request until it leaves the
// output register. After reset all TABLE_PAGES * 512 RAM words are cleared, one word
// per cycle, and no request is accepted until then; the root frame resets to 0.
module four_level_page_table_walker #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pgw_pkg::ROOT_W-1:0] cfg_wdata,
  pgw_req_if.sink                    in_ch,
  pgw_rsp_if.source                  out_ch
);

  localparam int DEPTH = TABLE_PAGES * 512;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [39:0] PAGES_40 = 40'(TABLE_PAGES);

  pgw_pkg::state_t state_r, state_nxt;

  logic [pgw_pkg::ROOT_W-1:0]  root_frame_r;
  logic [AW-1:0]               clr_cnt_r;
  logic [pgw_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [pgw_pkg::VA_W-1:0]    va_r;

  logic                          out_valid_r;
  logic [pgw_pkg::STATUS_W-1:0]  out_status_r;
  logic [pgw_pkg::PA_W-1:0]      out_phys_r;
  logic [pgw_pkg::SIZE_W-1:0]    out_size_r;
  logic [pgw_pkg::WORD_W-1:0]    out_leaf_r;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [pgw_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  logic in_fire, out_free, root_ok, clr_last;

  logic                          ev_done;
  logic [pgw_pkg::STATUS_W-1:0]  ev_status;
  logic [pgw_pkg::PA_W-1:0]      ev_phys;
  logic [pgw_pkg::SIZE_W-1:0]    ev_size;
  logic [39:0]                   ev_frame;

  logic                          res_load;
  logic [pgw_pkg::STATUS_W-1:0]  res_status;
  logic [pgw_pkg::PA_W-1:0]      res_phys;
  logic [pgw_pkg::SIZE_W-1:0]    res_size;
  logic [pgw_pkg::WORD_W-1:0]    res_leaf;

  function automatic logic [pgw_pkg::IDX_W-1:0] level_index(
    input logic [pgw_pkg::VA_W-1:0]    va,
    input logic [pgw_pkg::LEVEL_W-1:0] lvl
  );
    logic [pgw_pkg::IDX_W-1:0] idx;
    unique case (lvl)
      pgw_pkg::LVL_PML4: idx = va[47:39];
      pgw_pkg::LVL_PDPT: idx = va[38:30];
      pgw_pkg::LVL_PD:   idx = va[29:21];
      default:           idx = va[20:12];
    endcase
    return idx;
  endfunction

  pgw_ram #(
    .WIDTH (pgw_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_table_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == pgw_pkg::S_IDLE) && out_free;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign root_ok = 32'(root_frame_r) < 32'(TABLE_PAGES);
  assign clr_last = clr_cnt_r == AW'(DEPTH - 1);

  // Evaluate the table word read for the current level.
  always_comb begin
    ev_done   = 1'b1;
    ev_status = pgw_pkg::ST_OK;
    ev_phys   = '0;
    ev_size   = pgw_pkg::SZ_4K;
    ev_frame  = ram_rdata[51:12];
    if (!ram_rdata[pgw_pkg::BIT_PRESENT]) begin
      ev_status = pgw_pkg::ST_NOT_PRESENT;
    end else if (level_r == pgw_pkg::LVL_PT) begin
      ev_phys = {ram_rdata[51:12], va_r[11:0]};
    end else if (level_r == pgw_pkg::LVL_PDPT && ram_rdata[pgw_pkg::BIT_HUGE]) begin
      ev_phys = {ram_rdata[51:30], va_r[29:0]};
      ev_size = pgw_pkg::SZ_1G;
    end else if (level_r == pgw_pkg::LVL_PD && ram_rdata[pgw_pkg::BIT_HUGE]) begin
      ev_phys = {ram_rdata[51:21], va_r[20:0]};
      ev_size = pgw_pkg::SZ_2M;
    end else if (ev_frame >= PAGES_40) begin
      ev_status = pgw_pkg::ST_OUT_OF_STORE;
    end else begin
      ev_done = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pgw_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_nxt = pgw_pkg::S_IDLE;
        end
      end
      pgw_pkg::S_IDLE: begin
        if (in_fire && in_ch.opcode == pgw_pkg::OP_TRANSLATE && root_ok) begin
          state_nxt = pgw_pkg::S_WALK;
        end
      end
      pgw_pkg::S_WALK: begin
        if (ev_done && out_free) begin
          state_nxt = pgw_pkg::S_IDLE;
        end
      end
      default: state_nxt = pgw_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = AW'(in_ch.word_index);
    ram_wdata  = in_ch.word_value;
    ram_re     = 1'b0;
    ram_raddr  = AW'({root_frame_r, in_ch.virt_addr[47:39]});
    level_nxt  = level_r;
    res_load   = 1'b0;
    res_status = pgw_pkg::ST_OK;
    res_phys   = '0;
    res_size   = pgw_pkg::SZ_4K;
    res_leaf   = '0;
    unique case (state_r)
      pgw_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      pgw_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_ch.opcode == pgw_pkg::OP_WRITE) begin
            ram_we   = 32'(in_ch.word_index) < 32'(DEPTH);
            res_load = 1'b1;
          end else if (!root_ok) begin
            res_load   = 1'b1;
            res_status = pgw_pkg::ST_OUT_OF_STORE;
          end else begin
            ram_re    = 1'b1;
            level_nxt = pgw_pkg::LVL_PML4;
          end
        end
      end
      pgw_pkg::S_WALK: begin
        res_status = ev_status;
        res_phys   = ev_phys;
        res_size   = ev_size;
        res_leaf   = ram_rdata;
        if (ev_done) begin
          res_load = out_free;
        end else begin
          ram_re    = 1'b1;
          level_nxt = level_r + 2'd1;
          ram_raddr = AW'({ev_frame, level_index(va_r, level_r + 2'd1)});
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pgw_pkg::S_CLEAR;
      clr_cnt_r    <= '0;
      root_frame_r <= '0;
      level_r      <= pgw_pkg::LVL_PML4;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      if (state_r == pgw_pkg::S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cfg_we) begin
        root_frame_r <= cfg_wdata;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      va_r <= in_ch.virt_addr;
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_phys_r   <= res_phys;
      out_size_r   <= res_size;
      out_leaf_r   <= res_leaf;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.phys_addr = out_phys_r;
  assign out_ch.pg_size   = out_size_r;
  assign out_ch.leaf_word = out_leaf_r;

endmodule
